[rtl/fkue_pkg.sv]
// ============================================================================
// fkue_pkg: flash interface key unlock / page erase shared definitions
// Register indexes, key words, control and status bit positions, and the
// key machine state type.
// ============================================================================
`default_nettype none

package fkue_pkg;

    // Field widths
    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 5;
    localparam int PAGE_W      = 7;

    // Packed stream widths (fields padded to whole bytes)
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;

    // Access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Register word indexes
    localparam logic [INDEX_W-1:0] IDX_KEY     = 5'd2;
    localparam logic [INDEX_W-1:0] IDX_STATUS  = 5'd4;
    localparam logic [INDEX_W-1:0] IDX_CONTROL = 5'd5;

    // Unlock keys
    localparam logic [DATA_W-1:0] KEY_FIRST  = 32'h4567_0123;
    localparam logic [DATA_W-1:0] KEY_SECOND = 32'hCDEF_89AB;

    // Reset values
    localparam logic [DATA_W-1:0] CONTROL_RESET    = 32'hC000_0000;
    localparam logic [DATA_W-1:0] FLASH_BASE_RESET = 32'h0800_0000;

    // Status bits 15:0 are write-one-to-clear
    localparam logic [DATA_W-1:0] W1C_MASK = 32'h0000_FFFF;

    // Control and status bit positions
    localparam int BIT_LOCK   = 31;
    localparam int BIT_START  = 16;
    localparam int BIT_PER    = 1;
    localparam int BIT_WRPERR = 4;
    localparam int PAGE_LSB   = 3;

    // Key machine
    typedef enum logic [1:0] {
        KS_LOCKED   = 2'd0,
        KS_KEY1     = 2'd1,
        KS_UNLOCKED = 2'd2
    } key_state_t;

endpackage

`default_nettype wire

[rtl/flash_interface_key_unlock_erase.sv]
// ============================================================================
// flash_interface_key_unlock_erase: flash register block with key unlock
// Word-access register file, two-key unlock machine, lock bit handling,
// write-protect error flag and page erase range generation.
// ============================================================================
// Each result is registered: a request passes the input register and then the
// output register, and a stall on m_axis_tready can hold it in either.
// Throughput: one request per cycle; while a result waits, the input register
// takes one more request, then s_axis_tready drops until the result is taken.
// Reset (rst_n low, asynchronous): key machine locked, control 0xC0000000,
// all other words zero, base address 0x08000000, both stages empty.
`default_nettype none

module flash_interface_key_unlock_erase
    import fkue_pkg::*;
#(
    parameter int REG_WORDS  = 21,
    parameter int PAGE_BYTES = 2048,
    parameter int PAGE_COUNT = 128
)(
    input  wire                    clk,
    input  wire                    rst_n,

    // Configuration: flash base address
    input  wire                    cfg_we,
    input  wire [DATA_W-1:0]       cfg_wdata,

    // Request stream
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: reg_index[4:0], write_data[36:5], zero pad[39:37]
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: func[0]
    input  wire [0:0]              s_axis_tuser,

    // Result stream
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // tdata: read_data[31:0], erase_go[32], erase_first[64:33],
    //        erase_last[96:65], array_writable[97], zero pad[103:98]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int RF_IDX_W = $clog2(REG_WORDS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                 in_valid_reg,   in_valid_next;
    logic                 in_func_reg;
    logic [INDEX_W-1:0]   in_idx_reg;
    logic [DATA_W-1:0]    in_data_reg;

    logic                 out_valid_reg,  out_valid_next;
    logic [DATA_W-1:0]    out_rdata_reg,  out_rdata_next;
    logic                 out_go_reg,     out_go_next;
    logic [DATA_W-1:0]    out_first_reg,  out_first_next;
    logic [DATA_W-1:0]    out_last_reg,   out_last_next;
    logic                 out_wr_reg,     out_wr_next;

    logic [DATA_W-1:0]    base_reg;
    key_state_t           key_state_reg,  key_state_next;
    logic [DATA_W-1:0]    rf_reg  [REG_WORDS];
    logic [DATA_W-1:0]    rf_next [REG_WORDS];

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic s_accept;
    logic advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic                is_write;
    logic                in_range;
    logic                hit_key;
    logic                hit_status;
    logic                hit_control;
    logic [RF_IDX_W-1:0] rf_idx;
    logic                unlocked;

    assign is_write    = (in_func_reg == FUNC_WRITE);
    assign in_range    = ({27'd0, in_idx_reg} < 32'(REG_WORDS));
    assign hit_key     = (in_idx_reg == IDX_KEY);
    assign hit_status  = (in_idx_reg == IDX_STATUS);
    assign hit_control = (in_idx_reg == IDX_CONTROL);
    assign rf_idx      = in_idx_reg[RF_IDX_W-1:0];

    // ------------------------------------------------------------------
    // Key machine: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        key_state_next = key_state_reg;
        if (advance && is_write)
        begin
            if (hit_key)
            begin
                if (in_data_reg == KEY_FIRST)
                begin
                    key_state_next = KS_KEY1;
                end
                else if (in_data_reg == KEY_SECOND && key_state_reg == KS_KEY1)
                begin
                    key_state_next = KS_UNLOCKED;
                end
            end
            else
            begin
                unique case (key_state_reg)
                    KS_KEY1:     key_state_next = KS_LOCKED;
                    KS_UNLOCKED:
                    begin
                        // writing LOCK relocks
                        if (hit_control && in_data_reg[BIT_LOCK])
                        begin
                            key_state_next = KS_LOCKED;
                        end
                    end
                    default:     key_state_next = key_state_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Key machine: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (key_state_reg)
            KS_UNLOCKED: unlocked = 1'b1;
            default:     unlocked = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control word, erase request and page range
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] ctrl_val;
    logic              erase_req;
    logic              wp_error;
    logic [PAGE_W-1:0] page;
    logic              page_ok;
    logic [DATA_W-1:0] page_off;
    logic [DATA_W-1:0] erase_first;
    logic [DATA_W-1:0] erase_last;

    always_comb
    begin
        ctrl_val = in_data_reg;
        // LOCK stays set until unlocked
        if (!unlocked)
        begin
            ctrl_val[BIT_LOCK] = 1'b1;
        end
    end

    assign erase_req   = is_write && hit_control && ctrl_val[BIT_START] && ctrl_val[BIT_PER];
    assign wp_error    = erase_req && ctrl_val[BIT_LOCK];
    assign page        = ctrl_val[PAGE_LSB +: PAGE_W];
    assign page_ok     = ({1'b0, page} < 8'(PAGE_COUNT));
    assign page_off    = {{(DATA_W-PAGE_W){1'b0}}, page} * 32'(PAGE_BYTES);
    assign erase_first = base_reg + page_off;
    assign erase_last  = erase_first + 32'(PAGE_BYTES - 1);

    // ------------------------------------------------------------------
    // Register file update and read
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < REG_WORDS; i++)
        begin
            rf_next[i] = rf_reg[i];
        end
        if (advance && is_write)
        begin
            if (hit_control)
            begin
                rf_next[IDX_CONTROL] = ctrl_val & ~(32'd1 << BIT_START);
                if (wp_error)
                begin
                    rf_next[IDX_STATUS] = rf_reg[IDX_STATUS] | (32'd1 << BIT_WRPERR);
                end
            end
            else if (hit_status)
            begin
                rf_next[IDX_STATUS] = rf_reg[IDX_STATUS] & ~(in_data_reg & W1C_MASK);
            end
            else if (!hit_key && in_range)
            begin
                rf_next[rf_idx] = in_data_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    always_comb
    begin
        out_rdata_next = '0;
        if (!is_write && in_range)
        begin
            out_rdata_next = rf_reg[rf_idx];
            // control reads reflect the lock state
            if (hit_control)
            begin
                out_rdata_next[BIT_LOCK] = !unlocked;
            end
        end

        out_go_next    = erase_req && !ctrl_val[BIT_LOCK] && page_ok;
        out_first_next = out_go_next ? erase_first : '0;
        out_last_next  = out_go_next ? erase_last  : '0;
        out_wr_next    = (key_state_next == KS_UNLOCKED);
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_state_reg <= KS_LOCKED;
            base_reg      <= FLASH_BASE_RESET;
            for (int i = 0; i < REG_WORDS; i++)
            begin
                rf_reg[i] <= (i == int'(IDX_CONTROL)) ? CONTROL_RESET : '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            key_state_reg <= key_state_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            for (int i = 0; i < REG_WORDS; i++)
            begin
                rf_reg[i] <= rf_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_func_reg <= s_axis_tuser[0];
            in_idx_reg  <= s_axis_tdata[INDEX_W-1:0];
            in_data_reg <= s_axis_tdata[INDEX_W +: DATA_W];
        end
        if (advance)
        begin
            out_rdata_reg <= out_rdata_next;
            out_go_reg    <= out_go_next;
            out_first_reg <= out_first_next;
            out_last_reg  <= out_last_next;
            out_wr_reg    <= out_wr_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_wr_reg, out_last_reg, out_first_reg,
                            out_go_reg, out_rdata_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_go_needs_unlock: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_go_reg) |-> out_wr_reg)
        else $error("erase started while array not writable");

    a_writable_tracks_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_wr_reg == (key_state_reg == KS_UNLOCKED)))
        else $error("array_writable disagrees with key state");

    a_range_span: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_go_reg) |->
            ((out_last_reg - out_first_reg) == 32'(PAGE_BYTES - 1)))
        else $error("erase range does not span one page");

    a_range_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_go_reg) |->
            (out_first_reg == '0 && out_last_reg == '0))
        else $error("erase range set without erase");

    a_wp_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && wp_error) |=> rf_reg[IDX_STATUS][BIT_WRPERR])
        else $error("write-protect error flag not raised");

endmodule

`default_nettype wire
